FILE: hdl/keyword_abbrev_lookup_macros.svh
// Assertion macros for keyword_abbrev_lookup
`ifndef KEYWORD_ABBREV_LOOKUP_MACROS_SVH
`define KEYWORD_ABBREV_LOOKUP_MACROS_SVH
`define KAL_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("keyword_abbrev_lookup: %s", "label");
`define KAL_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("keyword_abbrev_lookup: %s", "label");
`endif

FILE: hdl/kal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kal_pkg
// Shared types and constants for the keyword lookup block.
// ----------------------------------------------------------------------------
package kal_pkg;
  localparam int ENTRIES_DEF = 64;
  localparam int MAX_NAME_LEN_DEF = 16;
  localparam int RESULT_CAP = 16;

  typedef enum logic [1:0] {
    OP_NAME  = 2'd0,
    OP_HDR   = 2'd1,
    OP_QUERY = 2'd2,
    OP_REV   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FHDR,
    ST_FCHR,
    ST_RHDR,
    ST_RCHR,
    ST_OUT
  } state_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7a) begin
      return c - 8'h20;
    end
    return c;
  endfunction
endpackage

FILE: hdl/keyword_abbrev_lookup.sv
`timescale 1ns / 1ps
// Loads and non-last query chars are taken in ST_IDLE. A last query char scans
// headers in ST_FHDR; a length candidate then compares name chars in ST_FCHR.
// The answer is valid the cycle after the scan ends.
// Reverse lookup: same header scan, then each name char via ST_RCHR and ST_OUT.
// One request at a time; input stalls during a scan and while a
// result waits. Reset: sync active low; header valid bits and query state cleared.
// ----------------------------------------------------------------------------
// keyword_abbrev_lookup
// Keyword table with short forms: forward and reverse lookup.
// ----------------------------------------------------------------------------
module keyword_abbrev_lookup #(
  parameter int ENTRIES = kal_pkg::ENTRIES_DEF,
  parameter int MAX_NAME_LEN = kal_pkg::MAX_NAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // op, entry, position, char_code, name_length,
                                 // short_length, token_in
  input  logic        in_tlast,  // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // token_out, found, name_char, final_res
  output logic        out_tuser  // kind
);
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int AW = EW + PW;
  localparam int QW = $clog2(MAX_NAME_LEN + 1);
  localparam int NL = (MAX_NAME_LEN < kal_pkg::RESULT_CAP) ? MAX_NAME_LEN
                                                          : kal_pkg::RESULT_CAP;

  logic [1:0]  f_op;
  logic [5:0]  f_ent;
  logic [3:0]  f_pos;
  logic [7:0]  f_ch;
  logic [4:0]  f_flen, f_slen;
  logic [15:0] f_tok;
  assign f_op   = in_tdata[1:0];
  assign f_ent  = in_tdata[7:2];
  assign f_pos  = in_tdata[11:8];
  assign f_ch   = in_tdata[19:12];
  assign f_flen = in_tdata[24:20];
  assign f_slen = in_tdata[29:25];
  assign f_tok  = in_tdata[45:30];

  kal_pkg::state_t st_r, st_nxt;
  logic [7:0]  qbuf_r [0:MAX_NAME_LEN-1];
  logic [QW-1:0] qcnt_r, qcnt_nxt;
  logic        qovl_r, qovl_nxt;
  logic [EW:0] idx_r, idx_nxt;
  logic [PW:0] k_r, k_nxt;
  logic [4:0]  n_r, n_nxt;
  logic [15:0] stok_r, stok_nxt;
  logic        ov_r, ov_nxt;
  logic [25:0] od_r, od_nxt;
  logic        ok_r, ok_nxt;

  logic        accept;
  assign accept = in_tvalid && in_tready;
  assign in_tready = (st_r == kal_pkg::ST_IDLE) && !ov_r;

  logic          nm_we, hd_we;
  logic [AW-1:0] nm_wa, nm_ra;
  logic [EW-1:0] hd_wa, hd_ra;
  logic [7:0]    nm_rd;
  logic [25:0]   hd_rd;
  logic          ent_ok;
  assign ent_ok = ({26'd0, f_ent} < 32'(ENTRIES));
  assign nm_we = accept && f_op == kal_pkg::OP_NAME && ent_ok
                 && ({28'd0, f_pos} < 32'(MAX_NAME_LEN));
  assign hd_we = accept && f_op == kal_pkg::OP_HDR && ent_ok;
  assign nm_wa = {f_ent[EW-1:0], f_pos[PW-1:0]};
  assign hd_wa = f_ent[EW-1:0];
  assign nm_ra = {idx_r[EW-1:0], k_r[PW-1:0]};
  assign hd_ra = idx_r[EW-1:0];

  kal_name_mem #(.AW(AW)) u_name (
    .clk(clk), .we(nm_we), .waddr(nm_wa), .wdata(f_ch),
    .raddr(nm_ra), .rdata(nm_rd)
  );
  kal_hdr_mem #(.ENTRIES(ENTRIES), .EW(EW)) u_hdr (
    .clk(clk), .rst_n(rst_n), .we(hd_we), .waddr(hd_wa),
    .wdata({f_tok, f_slen, f_flen}), .raddr(hd_ra), .rdata(hd_rd)
  );

  logic [4:0]  h_flen, h_slen;
  logic [15:0] h_tok;
  assign h_flen = hd_rd[4:0];
  assign h_slen = hd_rd[9:5];
  assign h_tok  = hd_rd[25:10];
  logic [4:0] qlen5;
  assign qlen5 = 5'(qcnt_r);
  logic cand;
  assign cand = (qlen5 == h_flen) || (qlen5 == h_slen);
  logic [4:0] nrev;
  assign nrev = (h_flen > 5'(NL)) ? 5'(NL) : h_flen;

  always_ff @(posedge clk) begin
    if (accept && f_op == kal_pkg::OP_QUERY && !qovl_r
        && {1'b0, qcnt_r} < (QW+1)'(MAX_NAME_LEN)) begin
      qbuf_r[qcnt_r[PW-1:0]] <= kal_pkg::fold_upper(f_ch);
    end
  end

  always_comb begin
    st_nxt = st_r; qcnt_nxt = qcnt_r; qovl_nxt = qovl_r;
    idx_nxt = idx_r; k_nxt = k_r; n_nxt = n_r; stok_nxt = stok_r;
    ov_nxt = ov_r; od_nxt = od_r; ok_nxt = ok_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      kal_pkg::ST_IDLE: begin
        if (accept && f_op == kal_pkg::OP_QUERY) begin
          if ({1'b0, qcnt_r} < (QW+1)'(MAX_NAME_LEN)) begin
            qcnt_nxt = qcnt_r + 1'b1;
          end else begin
            qovl_nxt = 1'b1;
          end
          if (in_tlast) begin
            idx_nxt = '0; k_nxt = '0;
            if (qovl_nxt) begin
              od_nxt = {1'b1, 8'd0, 1'b0, 16'd0}; ok_nxt = 1'b0; ov_nxt = 1'b1;
              qcnt_nxt = '0; qovl_nxt = 1'b0;
            end else begin
              st_nxt = kal_pkg::ST_FHDR;
            end
          end
        end else if (accept && f_op == kal_pkg::OP_REV) begin
          idx_nxt = '0; k_nxt = '0; stok_nxt = f_tok;
          st_nxt = kal_pkg::ST_RHDR;
        end
      end
      kal_pkg::ST_FHDR: begin
        // header data for idx_r valid in the k_r=1 phase (k_r used as phase)
        if (k_r == '0) begin
          k_nxt = (PW+1)'(1);
        end else begin
          k_nxt = '0;
          if (idx_r == (EW+1)'(ENTRIES) || h_flen == 5'd0) begin
            od_nxt = {1'b1, 8'd0, 1'b0, 16'd0}; ok_nxt = 1'b0; ov_nxt = 1'b1;
            qcnt_nxt = '0; st_nxt = kal_pkg::ST_IDLE;
          end else if (cand) begin
            stok_nxt = h_tok; n_nxt = qlen5;
            if (qlen5 == 5'd0) begin
              od_nxt = {1'b1, 8'd0, 1'b1, h_tok}; ok_nxt = 1'b0; ov_nxt = 1'b1;
              qcnt_nxt = '0; st_nxt = kal_pkg::ST_IDLE;
            end else begin
              st_nxt = kal_pkg::ST_FCHR;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (idx_r == (EW+1)'(ENTRIES) && k_r == '0) begin
          od_nxt = {1'b1, 8'd0, 1'b0, 16'd0}; ok_nxt = 1'b0; ov_nxt = 1'b1;
          qcnt_nxt = '0; st_nxt = kal_pkg::ST_IDLE; k_nxt = '0;
        end
      end
      kal_pkg::ST_FCHR: begin
        // k_r addresses the read; when k_r>0 the registered nm_rd holds char k_r-1 for the compare
        if (k_r != '0 && nm_rd != qbuf_r[PW'(k_r - 1'b1)]) begin
          idx_nxt = idx_r + 1'b1; k_nxt = '0; st_nxt = kal_pkg::ST_FHDR;
        end else if (5'(k_r) == n_r && k_r != '0) begin
          od_nxt = {1'b1, 8'd0, 1'b1, stok_r}; ok_nxt = 1'b0; ov_nxt = 1'b1;
          qcnt_nxt = '0; k_nxt = '0; st_nxt = kal_pkg::ST_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      kal_pkg::ST_RHDR: begin
        if (k_r == '0) begin
          k_nxt = (PW+1)'(1);
          if (idx_r == (EW+1)'(ENTRIES)) begin
            od_nxt = {1'b1, 8'd0, 1'b0, 16'd0}; ok_nxt = 1'b1; ov_nxt = 1'b1;
            k_nxt = '0; st_nxt = kal_pkg::ST_IDLE;
          end
        end else begin
          k_nxt = '0;
          if (h_flen == 5'd0) begin
            od_nxt = {1'b1, 8'd0, 1'b0, 16'd0}; ok_nxt = 1'b1; ov_nxt = 1'b1;
            st_nxt = kal_pkg::ST_IDLE;
          end else if (h_tok == stok_r) begin
            n_nxt = nrev; st_nxt = kal_pkg::ST_RCHR;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      kal_pkg::ST_RCHR: begin
        // read issued at k_r; data next cycle in ST_OUT
        st_nxt = kal_pkg::ST_OUT;
      end
      kal_pkg::ST_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; ok_nxt = 1'b1;
          od_nxt = {5'(k_r + 1'b1) == n_r, nm_rd, 1'b1, stok_r};
          k_nxt = k_r + 1'b1;
          st_nxt = (5'(k_r + 1'b1) == n_r) ? kal_pkg::ST_IDLE : kal_pkg::ST_RCHR;
          if (5'(k_r + 1'b1) == n_r) begin
            k_nxt = '0;
          end
        end
      end
      default: st_nxt = kal_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= kal_pkg::ST_IDLE; qcnt_r <= '0; qovl_r <= 1'b0;
      idx_r <= '0; k_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; qcnt_r <= qcnt_nxt; qovl_r <= qovl_nxt;
      idx_r <= idx_nxt; k_r <= k_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt; stok_r <= stok_nxt; od_r <= od_nxt; ok_r <= ok_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, od_r};
  assign out_tuser  = ok_r;
endmodule

FILE: hdl/kal_name_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kal_name_mem
// Name character store, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kal_name_mem #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/kal_hdr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kal_hdr_mem
// Entry header store (lengths and token) with valid bits; an entry never
// written reads as zero.
// ----------------------------------------------------------------------------
module kal_hdr_mem #(
  parameter int ENTRIES = kal_pkg::ENTRIES_DEF,
  parameter int EW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [EW-1:0] waddr,
  input  logic [25:0]   wdata,
  input  logic [EW-1:0] raddr,
  output logic [25:0]   rdata
);
  logic [25:0]        mem [0:ENTRIES-1];
  logic [ENTRIES-1:0] vld_r;
  logic [25:0]        q_r;
  logic               qv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      qv_r <= vld_r[raddr];
    end
  end

  assign rdata = qv_r ? q_r : 26'd0;
endmodule

FILE: hdl/kal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kal_checker
// Port-level checks for keyword_abbrev_lookup.
// ----------------------------------------------------------------------------
`include "keyword_abbrev_lookup_macros.svh"
module kal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);
  `KAL_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `KAL_ASSERT_IMPL(a_fwd_fin, clk, rst_n, out_tvalid && !out_tuser, out_tdata[25])
  `KAL_ASSERT_IMPL(a_miss_zero, clk, rst_n, out_tvalid && !out_tdata[16],
                   out_tdata[15:0] == 16'd0 && out_tdata[24:17] == 8'd0)
  `KAL_ASSERT_IMPL(a_busy, clk, rst_n, out_tvalid && !out_tready, !in_tready)
endmodule

bind keyword_abbrev_lookup kal_checker u_kal_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
